/* rtl/sbh_pkg.sv */
// shared constants, types and state codes for the string bucket hash block
// no dependencies; imported by every module of the block
package sbh_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned HBITS_W     = 6;
  localparam int unsigned BUCKET_W    = 20;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [WORD_BITS-1:0] POLY_MOD = 32'd4294967029;
  localparam logic [WORD_BITS-1:0] FIB_MULT = 32'd2654435769;

  // hash queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // division steps, one quotient bit per cycle
  localparam int unsigned DIV_CNT_W = $clog2(WORD_BITS);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_BITS    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_COUNT = 1'd1;

  // configuration seen by the back end
  typedef struct packed {
    logic [HBITS_W-1:0]  hash_bits;
    logic [BUCKET_W-1:0] bucket_count;
  } sbh_cfg_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TOP,
    ST_DIV,
    ST_OUT
  } sbh_state_t;

endpackage

/* rtl/sbh_front.sv */
// front end: takes key bytes and runs the polynomial accumulator
// depends on sbh_pkg; pushes finished accumulators into sbh_queue
module sbh_front import sbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_BITS-1:0] key_byte,
  input  logic                 queue_full,
  output logic                 push,
  output logic [WORD_BITS-1:0] push_data
);

  logic [WORD_BITS-1:0] accumulator;
  logic [WORD_BITS-1:0] accumulator_next;
  logic [WORD_BITS-1:0] poly_sum;
  logic                 accept;

  // hold off new words while the queue has no room
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // 257*acc + byte with 32-bit wrap, then one conditional subtract
  assign poly_sum = (accumulator << BYTE_BITS) + accumulator
                    + {{(WORD_BITS-BYTE_BITS){1'b0}}, key_byte};
  assign accumulator_next = (poly_sum >= POLY_MOD) ? (poly_sum - POLY_MOD) : poly_sum;

  // terminating zero byte hands the accumulator over
  assign push      = accept && (key_byte == '0);
  assign push_data = accumulator;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
    end else if (accept) begin
      if (key_byte == '0) begin
        accumulator <= '0;
      end else begin
        accumulator <= accumulator_next;
      end
    end
  end

endmodule

/* rtl/sbh_queue.sv */
// short first-in first-out queue of finished string accumulators
// depends on sbh_pkg; sits between sbh_front and sbh_back
module sbh_queue import sbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WORD_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] pop_data,
  output logic                 not_empty,
  output logic                 full
);

  logic [WORD_BITS-1:0] entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    fill;
  logic                 do_push;
  logic                 do_pop;

  assign not_empty = (fill != '0);
  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/sbh_back.sv */
// back end: multiplicative hash, top-bit select and bucket remainder
// depends on sbh_pkg; pops sbh_queue and drives the result word registers
module sbh_back import sbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  sbh_cfg_t             cfg,
  input  logic                 queue_not_empty,
  input  logic [WORD_BITS-1:0] queue_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] hash_value,
  output logic [BUCKET_W-1:0]  bucket_index
);

  sbh_state_t state;
  sbh_state_t state_next;

  logic [WORD_BITS-1:0] acc_reg;
  logic [WORD_BITS-1:0] product;
  logic [WORD_BITS-1:0] hash_reg;
  logic [WORD_BITS-1:0] dividend;
  logic [BUCKET_W:0]    remainder;
  logic [DIV_CNT_W-1:0] div_count;

  logic [WORD_BITS-1:0] top_value;
  logic [HBITS_W-1:0]   shift_amt;
  logic [BUCKET_W:0]    trial;
  logic [BUCKET_W:0]    divisor_ext;
  logic                 out_free;
  logic                 load_out;

  // output register may be refilled when empty or being taken
  assign out_free = !out_valid || !out_stall;

  // keep the top hash_bits bits of the product
  assign shift_amt = HBITS_W'(WORD_BITS) - cfg.hash_bits;
  always_comb begin
    if (cfg.hash_bits == '0) begin
      top_value = '0;
    end else if (cfg.hash_bits >= HBITS_W'(WORD_BITS)) begin
      top_value = product;
    end else begin
      top_value = product >> shift_amt;
    end
  end

  // restoring division step, one quotient bit per cycle
  assign divisor_ext = {1'b0, cfg.bucket_count};
  assign trial       = {remainder[BUCKET_W-1:0], dividend[WORD_BITS-1]};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (queue_not_empty) begin
          pop        = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_TOP;
      end
      ST_TOP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_count == DIV_CNT_W'(WORD_BITS - 1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc_reg <= queue_data;
      end
      ST_MUL: begin
        product <= acc_reg * FIB_MULT;
      end
      ST_TOP: begin
        hash_reg  <= top_value;
        dividend  <= top_value;
        remainder <= '0;
        div_count <= '0;
      end
      ST_DIV: begin
        if (trial >= divisor_ext) begin
          remainder <= trial - divisor_ext;
        end else begin
          remainder <= trial;
        end
        dividend  <= dividend << 1;
        div_count <= div_count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hash_value   <= hash_reg;
      bucket_index <= (cfg.bucket_count == '0) ? '0 : remainder[BUCKET_W-1:0];
    end
  end

endmodule

/* rtl/string_bucket_hash.sv */
// Polynomial string hash with Fibonacci bucket selection. Key bytes arrive one word per
// cycle on the input channel while in_stall is low; a zero byte ends the string and
// produces one result word carrying hash_value and bucket_index, other bytes produce
// nothing. Each finished string waits in a four-deep queue for the back end: a
// multiply, a top-bit select and a 32-step restoring division for the bucket remainder.
// The front end takes a byte every cycle, stalling input only while the queue is full.
// The user must write hash_bits and bucket_count through the configuration port only
// while the block is idle, which it does not enforce. Reset leaves them at 5 and 16.
// top level: holds configuration registers, instantiates front, queue and back
// depends on sbh_pkg, sbh_front, sbh_queue, sbh_back
module string_bucket_hash import sbh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_BITS-1:0]   key_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_BITS-1:0]   hash_value,
  output logic [BUCKET_W-1:0]    bucket_index
);

  sbh_cfg_t             cfg;
  logic                 queue_full;
  logic                 queue_not_empty;
  logic                 push;
  logic [WORD_BITS-1:0] push_data;
  logic                 pop;
  logic [WORD_BITS-1:0] pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hash_bits    <= HBITS_W'(5);
      cfg.bucket_count <= BUCKET_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HASH_BITS:    cfg.hash_bits    <= cfg_data[HBITS_W-1:0];
        REG_BUCKET_COUNT: cfg.bucket_count <= cfg_data[BUCKET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_byte   (key_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  sbh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_not_empty),
    .full      (queue_full)
  );

  sbh_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .queue_not_empty (queue_not_empty),
    .queue_data      (pop_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hash_value      (hash_value),
    .bucket_index    (bucket_index)
  );

endmodule

/* bench/sbh_checker.sv */
// checker for string_bucket_hash: follows the config port, predicts each result word
// from the key bytes taken by the block and compares it with the word the block returns
// depends on sbh_pkg
module sbh_checker import sbh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [BYTE_BITS-1:0]   key_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [WORD_BITS-1:0]   hash_value,
  input  logic [BUCKET_W-1:0]    bucket_index,
  output int                     fault_count,
  output int                     results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   REPORT_LIMIT  = 10;
  localparam logic [WORD_BITS-1:0] POLY_MULT     = 32'd257;
  localparam logic [HBITS_W-1:0]   HBITS_RESET   = 6'd5;
  localparam logic [BUCKET_W-1:0]  BUCKETS_RESET = 20'd16;

  typedef struct packed {
    logic [WORD_BITS-1:0] hash;
    logic [BUCKET_W-1:0]  bucket;
  } bucket_pick_t;

  logic [WORD_BITS-1:0] key_acc;
  logic [HBITS_W-1:0]   top_count;
  logic [BUCKET_W-1:0]  buckets;
  bucket_pick_t         picks_due[$];
  bucket_pick_t         want;
  int                   faults = 0;

  // one key byte into the running polynomial, product and sum wrap at 32 bits
  function automatic logic [WORD_BITS-1:0] fold_byte(input logic [WORD_BITS-1:0] acc,
                                                     input logic [BYTE_BITS-1:0] b);
    logic [WORD_BITS-1:0] wide_b;
    logic [WORD_BITS-1:0] sum;
    wide_b = {{(WORD_BITS-BYTE_BITS){1'b0}}, b};
    sum = acc * POLY_MULT + wide_b;
    return sum % POLY_MOD;
  endfunction

  // fibonacci multiply, keep the top bits, then the bucket remainder
  function automatic bucket_pick_t pick_bucket(input logic [WORD_BITS-1:0] acc,
                                               input logic [HBITS_W-1:0]   keep,
                                               input logic [BUCKET_W-1:0]  count);
    logic [WORD_BITS-1:0] product;
    logic [WORD_BITS-1:0] wide_count;
    logic [WORD_BITS-1:0] rem;
    bucket_pick_t         pick;
    product = acc * FIB_MULT;
    if (keep == 0) begin
      pick.hash = '0;
    end else if (keep >= WORD_BITS) begin
      pick.hash = product;
    end else begin
      pick.hash = product >> (WORD_BITS - keep);
    end
    wide_count = {{(WORD_BITS-BUCKET_W){1'b0}}, count};
    if (count == 0) begin
      rem = '0;
    end else begin
      rem = pick.hash % wide_count;
    end
    pick.bucket = rem[BUCKET_W-1:0];
    return pick;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_acc   = '0;
      top_count = HBITS_RESET;
      buckets   = BUCKETS_RESET;
      picks_due.delete();
    end else begin
      // result word leaving the block
      if (out_valid && !out_stall) begin
        if (picks_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("%0t: result word with none due: hash %h bucket %h",
                     $realtime, hash_value, bucket_index);
          end
        end else begin
          want = picks_due.pop_front();
          if (hash_value !== want.hash || bucket_index !== want.bucket) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("%0t: hash expected %h got %h, bucket expected %h got %h",
                       $realtime, want.hash, hash_value, want.bucket, bucket_index);
            end
          end
        end
      end
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_HASH_BITS: begin
            top_count = cfg_data[HBITS_W-1:0];
          end
          REG_BUCKET_COUNT: begin
            buckets = cfg_data[BUCKET_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // key word entering the block
      if (in_valid && !in_stall) begin
        if (key_byte != 0) begin
          key_acc = fold_byte(key_acc, key_byte);
        end else begin
          picks_due.push_back(pick_bucket(key_acc, top_count, buckets));
          key_acc = '0;
        end
      end
    end
    results_owed = picks_due.size();
    fault_count  = faults;
  end

endmodule

/* bench/tb_string_bucket_hash.sv */
// top of the string_bucket_hash bench: clock, reset, key strings, config phases and verdict
// depends on sbh_pkg, string_bucket_hash and sbh_checker
module tb_string_bucket_hash;
  timeunit 1ns;
  timeprecision 1ps;
  import sbh_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int QUIET_CYCLES    = 80;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 225;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_BITS-1:0]   key_byte;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [WORD_BITS-1:0]   hash_value;
  logic [BUCKET_W-1:0]    bucket_index;

  int fault_count;
  int results_owed;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count;

  string_bucket_hash dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_byte     (key_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

  sbh_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_byte     (key_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value),
    .bucket_index (bucket_index),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL string_bucket_hash");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one key word, with random sender gaps ahead of it
  task automatic send_byte(input logic [BYTE_BITS-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    key_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random non-zero bytes closed by the terminating zero
  task automatic send_key(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(1, 255)));
    end
    send_byte(8'd0);
  endtask

  // bytes 253, 5, then a third near 253, leave the accumulator just under where 257*acc wraps
  task automatic send_wrap_key(input logic [BYTE_BITS-1:0] third,
                               input logic [BYTE_BITS-1:0] fourth);
    send_byte(8'd253);
    send_byte(8'd5);
    send_byte(third);
    send_byte(fourth);
    send_byte(8'd0);
  endtask

  // let every due result out, then give the back end time to go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [HBITS_W-1:0] hb, input logic [BUCKET_W-1:0] bc);
    cfg_write <= 1'b1;
    cfg_index <= REG_HASH_BITS;
    cfg_data  <= {{(CFG_DATA_W-HBITS_W){1'b0}}, hb};
    @(negedge clk);
    cfg_index <= REG_BUCKET_COUNT;
    cfg_data  <= bc;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [HBITS_W-1:0]  hb;
    logic [BUCKET_W-1:0] bc;
    int                  sent;
    int                  len;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_HASH_BITS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    key_byte  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty key, byte extremes, modulus corners
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(8'd1);
    send_byte(8'd128);
    send_byte(8'd0);
    // sum lands exactly on the modulus
    send_wrap_key(8'd251, 8'd248);
    // sum lands just above the modulus
    send_wrap_key(8'd252, 8'd255);
    // product plus byte wraps past 32 bits to zero
    send_wrap_key(8'd253, 8'd1);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin hb = 6'd32; bc = 20'hFFFFF; end
        1: begin hb = 6'd1;  bc = 20'd1; end
        2: begin hb = 6'd0;  bc = 20'd0; end
        3: begin hb = 6'd63; bc = 20'd1048560; end
        4: begin hb = 6'd33; bc = 20'd7; end
        5: begin hb = 6'd16; bc = 20'd1000; end
        6: begin
          hb = 6'($urandom_range(63));
          bc = 20'($urandom_range(1, 300));
        end
        default: begin
          hb = 6'($urandom_range(63));
          bc = 20'($urandom_range(20'hFFFFF));
        end
      endcase
      load_config(hb, bc);
      // idle mix: none, sender gaps, receiver stalls, light both
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0; end
        1: begin idle_pct = 69; stall_pct = 0; end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(15) == 0) begin
          len = $urandom_range(48);
        end else begin
          len = $urandom_range(10);
        end
        send_key(len);
        sent += len + 1;
      end
      drain();
    end

    if (fault_count == 0) begin
      $display("PASS string_bucket_hash");
    end else begin
      $display("FAIL string_bucket_hash");
    end
    $finish;
  end

endmodule
